FILE: src/bfsp_pkg.sv
// ----------------------------------------------------------------------------
// Bellman-Ford shortest paths: shared package
// Sizes, codes and entry types used by every module of the block.
// ----------------------------------------------------------------------------
package bfsp_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 1024;

  localparam int VIDX_W   = $clog2(MAX_VERTICES);
  localparam int VCNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int EADDR_W  = $clog2(MAX_EDGES);
  localparam int ECNT_W   = $clog2(MAX_EDGES + 1);
  localparam int WEIGHT_W = 32;
  localparam int DIST_W   = 48;
  localparam int CFG_W    = 7;

  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  // Command codes of an input beat.
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_RUN   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NEG_CYC = 2'd1;
  localparam logic [1:0] ST_BAD_SRC = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [VIDX_W-1:0]          tail;
    logic [VIDX_W-1:0]          head;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic                     reach;
    logic signed [DIST_W-1:0] dval;
  } dist_ent_t;

  // Request bundle for one distance memory.
  typedef struct packed {
    logic              rd_en;
    logic [VIDX_W-1:0] rd_addr;
    logic              wr_en;
    logic [VIDX_W-1:0] wr_addr;
    dist_ent_t         wr_data;
  } dmem_req_t;

endpackage

FILE: src/bfsp_in_if.sv
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface bfsp_in_if import bfsp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 func;
  logic [VIDX_W-1:0]          from_vertex;
  logic [VIDX_W-1:0]          to_vertex;
  logic signed [WEIGHT_W-1:0] edge_weight;

  modport source (output valid, func, from_vertex, to_vertex, edge_weight, input ready);
  modport sink   (input valid, func, from_vertex, to_vertex, edge_weight, output ready);
endinterface

FILE: src/bfsp_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface bfsp_out_if import bfsp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [VIDX_W-1:0]        vertex_index;
  logic signed [DIST_W-1:0] distance;
  logic                     reachable;
  logic [1:0]               status;
  logic                     last;

  modport source (output valid, vertex_index, distance, reachable, status, last,
                  input ready);
  modport sink   (input valid, vertex_index, distance, reachable, status, last,
                  output ready);
endinterface

FILE: src/bfsp_edge_mem.sv
// ----------------------------------------------------------------------------
// Edge table memory
// One write port and one registered read port over the stored edges.
// ----------------------------------------------------------------------------
module bfsp_edge_mem import bfsp_pkg::*; (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [EADDR_W-1:0] wr_addr,
  input  edge_t              wr_data,
  input  logic               rd_en,
  input  logic [EADDR_W-1:0] rd_addr,
  output edge_t              rd_data
);

  edge_t mem [MAX_EDGES];
  edge_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/bfsp_dist_mem.sv
// ----------------------------------------------------------------------------
// Distance vector memory
// One distance vector with a write port and a registered read port.
// ----------------------------------------------------------------------------
module bfsp_dist_mem import bfsp_pkg::*; (
  input  logic      clk,
  input  dmem_req_t req,
  output dist_ent_t rd_data
);

  dist_ent_t mem [MAX_VERTICES];
  dist_ent_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/bellman_ford_shortest_paths.sv
// ----------------------------------------------------------------------------
// Bellman-Ford shortest paths
// Edge table loader and Bellman-Ford sequencer over two distance memories.
// ----------------------------------------------------------------------------
// Load and clear beats each return one result. A run with n vertices and E
// stored edges first sets up both vectors, then per round takes one edge at
// a time through read, add, compare and write back on the next-distance
// memory, then compares and copies the next vector into the current one, at
// most n rounds; the results then leave one beat per vertex, waiting while
// the output stalls. The edge-at-a-time walk is what sets the run time.
// No input beat is taken while a run is in progress.
module bellman_ford_shortest_paths import bfsp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  bfsp_in_if.sink          in_ch,
  bfsp_out_if.source       out_ch
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_INIT  = 10'b0000000010,
    S_E_RD  = 10'b0000000100,
    S_E_OP  = 10'b0000001000,
    S_E_SUM = 10'b0000010000,
    S_E_WR  = 10'b0000100000,
    S_S_RD  = 10'b0001000000,
    S_S_CMP = 10'b0010000000,
    S_O_RD  = 10'b0100000000,
    S_O_LD  = 10'b1000000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CFG_W-1:0]         vcnt_r, vcnt_nxt;
  logic [VCNT_W-1:0]        n_r, n_nxt;
  logic [VIDX_W-1:0]        src_r, src_nxt;
  logic [ECNT_W-1:0]        etot_r, etot_nxt;
  logic [ECNT_W-1:0]        e_r, e_nxt;
  logic [VCNT_W-1:0]        v_r, v_nxt;
  logic [VCNT_W-1:0]        rc_r, rc_nxt;
  logic                     extra_r, extra_nxt;
  logic                     changed_r, changed_nxt;
  logic [VIDX_W-1:0]        head_r, head_nxt;
  logic signed [WEIGHT_W-1:0] weight_r, weight_nxt;
  logic                     ok_r, ok_nxt;
  logic signed [DIST_W-1:0] sum_r, sum_nxt;
  logic                     ovalid_r, ovalid_nxt;
  logic [VIDX_W-1:0]        ovi_r, ovi_nxt;
  logic signed [DIST_W-1:0] odist_r, odist_nxt;
  logic                     oreach_r, oreach_nxt;
  logic [1:0]               ostat_r, ostat_nxt;
  logic                     olast_r, olast_nxt;

  logic [VCNT_W-1:0]        n_eff;
  logic                     in_acc;
  logic                     out_free;
  logic                     e_wr_en, e_rd_en;
  edge_t                    e_wr_data, e_rd_data;
  dmem_req_t                cur_req, nxt_req;
  dist_ent_t                cur_q, nxt_q;
  logic signed [DIST_W:0]   sum_wide;
  logic                     diff;
  logic                     better;

  // Storage.
  bfsp_edge_mem u_edge_mem (
    .clk     (clk),
    .wr_en   (e_wr_en),
    .wr_addr (etot_r[EADDR_W-1:0]),
    .wr_data (e_wr_data),
    .rd_en   (e_rd_en),
    .rd_addr (e_r[EADDR_W-1:0]),
    .rd_data (e_rd_data)
  );

  bfsp_dist_mem u_cur_mem (.clk(clk), .req(cur_req), .rd_data(cur_q));
  bfsp_dist_mem u_nxt_mem (.clk(clk), .req(nxt_req), .rd_data(nxt_q));

  // Effective vertex count: zero acts as one, large values are clamped.
  always_comb begin
    if (vcnt_r == '0) begin
      n_eff = VCNT_W'(1);
    end else if (vcnt_r > CFG_W'(MAX_VERTICES)) begin
      n_eff = VCNT_W'(MAX_VERTICES);
    end else begin
      n_eff = VCNT_W'(vcnt_r);
    end
  end

  assign out_free     = !ovalid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && out_free;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign e_wr_en   = in_acc && (in_ch.func == FUNC_LOAD) &&
                     (etot_r < ECNT_W'(MAX_EDGES));
  assign e_wr_data = '{tail: in_ch.from_vertex, head: in_ch.to_vertex,
                       weight: in_ch.edge_weight};
  assign e_rd_en   = (state_r == S_E_RD);

  // Wide sum of a tail distance and an edge weight; saturated into sum_r.
  assign sum_wide = {cur_q.dval[DIST_W-1], cur_q.dval} +
                    {{(DIST_W+1-WEIGHT_W){weight_r[WEIGHT_W-1]}}, weight_r};

  assign diff   = (nxt_q.reach != cur_q.reach) ||
                  (nxt_q.reach && (nxt_q.dval != cur_q.dval));
  assign better = ok_r && (!nxt_q.reach || (sum_r < nxt_q.dval));

  // Memory requests. Each edge completes before the next starts, so no
  // read of the next vector can overlap a pending write to it.
  always_comb begin
    cur_req = '0;
    nxt_req = '0;
    case (state_r)
      S_INIT: begin
        cur_req.wr_en   = 1'b1;
        cur_req.wr_addr = v_r[VIDX_W-1:0];
        cur_req.wr_data = '{reach: (v_r[VIDX_W-1:0] == src_r), dval: '0};
        nxt_req.wr_en   = 1'b1;
        nxt_req.wr_addr = v_r[VIDX_W-1:0];
        nxt_req.wr_data = '{reach: (v_r[VIDX_W-1:0] == src_r), dval: '0};
      end
      S_E_OP: begin
        cur_req.rd_en   = 1'b1;
        cur_req.rd_addr = e_rd_data.tail;
        nxt_req.rd_en   = 1'b1;
        nxt_req.rd_addr = e_rd_data.head;
      end
      S_E_WR: begin
        nxt_req.wr_en   = better;
        nxt_req.wr_addr = head_r;
        nxt_req.wr_data = '{reach: 1'b1, dval: sum_r};
      end
      S_S_RD: begin
        cur_req.rd_en   = 1'b1;
        cur_req.rd_addr = v_r[VIDX_W-1:0];
        nxt_req.rd_en   = 1'b1;
        nxt_req.rd_addr = v_r[VIDX_W-1:0];
      end
      S_S_CMP: begin
        cur_req.wr_en   = 1'b1;
        cur_req.wr_addr = v_r[VIDX_W-1:0];
        cur_req.wr_data = nxt_q;
      end
      S_O_RD: begin
        cur_req.rd_en   = out_free;
        cur_req.rd_addr = v_r[VIDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    vcnt_nxt    = vcnt_r;
    n_nxt       = n_r;
    src_nxt     = src_r;
    etot_nxt    = etot_r;
    e_nxt       = e_r;
    v_nxt       = v_r;
    rc_nxt      = rc_r;
    extra_nxt   = extra_r;
    changed_nxt = changed_r;
    head_nxt    = head_r;
    weight_nxt  = weight_r;
    ok_nxt      = ok_r;
    sum_nxt     = sum_r;
    ovalid_nxt  = ovalid_r && !out_ch.ready;
    ovi_nxt     = ovi_r;
    odist_nxt   = odist_r;
    oreach_nxt  = oreach_r;
    ostat_nxt   = ostat_r;
    olast_nxt   = olast_r;

    if (cfg_wr_en) begin
      vcnt_nxt = cfg_wr_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ovi_nxt    = '0;
          odist_nxt  = '0;
          oreach_nxt = 1'b0;
          olast_nxt  = 1'b1;
          ostat_nxt  = ST_OK;
          case (in_ch.func)
            FUNC_LOAD: begin
              ovalid_nxt = 1'b1;
              if (etot_r < ECNT_W'(MAX_EDGES)) begin
                etot_nxt = etot_r + ECNT_W'(1);
              end else begin
                ostat_nxt = ST_FULL;
              end
            end
            FUNC_CLEAR: begin
              ovalid_nxt = 1'b1;
              etot_nxt   = '0;
            end
            FUNC_RUN: begin
              if (VCNT_W'(in_ch.from_vertex) >= n_eff) begin
                ovalid_nxt = 1'b1;
                ostat_nxt  = ST_BAD_SRC;
              end else begin
                n_nxt     = n_eff;
                src_nxt   = in_ch.from_vertex;
                v_nxt     = '0;
                state_nxt = S_INIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Set both vectors: only the source is reached, at distance zero.
      S_INIT: begin
        v_nxt = v_r + VCNT_W'(1);
        if (v_r + VCNT_W'(1) == n_r) begin
          rc_nxt      = '0;
          extra_nxt   = !(n_r > VCNT_W'(1));
          changed_nxt = 1'b0;
          e_nxt       = '0;
          v_nxt       = '0;
          state_nxt   = (etot_r == '0) ? S_S_RD : S_E_RD;
        end
      end

      S_E_RD: begin
        state_nxt = S_E_OP;
      end

      // Edge arrives; fetch its tail and head distances.
      S_E_OP: begin
        head_nxt   = e_rd_data.head;
        weight_nxt = e_rd_data.weight;
        ok_nxt     = (VCNT_W'(e_rd_data.tail) < n_r) && (VCNT_W'(e_rd_data.head) < n_r);
        state_nxt  = S_E_SUM;
      end

      S_E_SUM: begin
        if (sum_wide[DIST_W] != sum_wide[DIST_W-1]) begin
          sum_nxt = sum_wide[DIST_W] ? DIST_MIN : DIST_MAX;
        end else begin
          sum_nxt = sum_wide[DIST_W-1:0];
        end
        ok_nxt    = ok_r && cur_q.reach;
        state_nxt = S_E_WR;
      end

      S_E_WR: begin
        e_nxt = e_r + ECNT_W'(1);
        if (e_r + ECNT_W'(1) == etot_r) begin
          v_nxt     = '0;
          state_nxt = S_S_RD;
        end else begin
          state_nxt = S_E_RD;
        end
      end

      S_S_RD: begin
        state_nxt = S_S_CMP;
      end

      // Compare next against current and copy it across.
      S_S_CMP: begin
        changed_nxt = changed_r || diff;
        v_nxt       = v_r + VCNT_W'(1);
        state_nxt   = S_S_RD;
        if (v_r + VCNT_W'(1) == n_r) begin
          rc_nxt      = rc_r + VCNT_W'(1);
          v_nxt       = '0;
          changed_nxt = 1'b0;
          e_nxt       = '0;
          if (!(changed_r || diff)) begin
            state_nxt = S_O_RD;
          end else if (extra_r) begin
            ovalid_nxt = 1'b1;
            ovi_nxt    = '0;
            odist_nxt  = '0;
            oreach_nxt = 1'b0;
            ostat_nxt  = ST_NEG_CYC;
            olast_nxt  = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            extra_nxt = !(rc_r + VCNT_W'(2) < n_r);
            state_nxt = (etot_r == '0) ? S_S_RD : S_E_RD;
          end
        end
      end

      S_O_RD: begin
        if (out_free) begin
          state_nxt = S_O_LD;
        end
      end

      // One distance beat per vertex.
      S_O_LD: begin
        ovalid_nxt = 1'b1;
        ovi_nxt    = v_r[VIDX_W-1:0];
        odist_nxt  = cur_q.reach ? cur_q.dval : DIST_MAX;
        oreach_nxt = cur_q.reach;
        ostat_nxt  = ST_OK;
        olast_nxt  = (v_r + VCNT_W'(1) == n_r);
        v_nxt      = v_r + VCNT_W'(1);
        state_nxt  = (v_r + VCNT_W'(1) == n_r) ? S_IDLE : S_O_RD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      vcnt_r    <= CFG_W'(MAX_VERTICES);
      etot_r    <= '0;
      rc_r      <= '0;
      ovalid_r  <= 1'b0;
      extra_r   <= 1'b0;
      changed_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      vcnt_r    <= vcnt_nxt;
      etot_r    <= etot_nxt;
      rc_r      <= rc_nxt;
      ovalid_r  <= ovalid_nxt;
      extra_r   <= extra_nxt;
      changed_r <= changed_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    src_r    <= src_nxt;
    e_r      <= e_nxt;
    v_r      <= v_nxt;
    head_r   <= head_nxt;
    weight_r <= weight_nxt;
    ok_r     <= ok_nxt;
    sum_r    <= sum_nxt;
    ovi_r    <= ovi_nxt;
    odist_r  <= odist_nxt;
    oreach_r <= oreach_nxt;
    ostat_r  <= ostat_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.vertex_index = ovi_r;
  assign out_ch.distance     = odist_r;
  assign out_ch.reachable    = oreach_r;
  assign out_ch.status       = ostat_r;
  assign out_ch.last         = olast_r;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bellman-Ford shortest paths: testbench
// Loads random edge tables, runs the search from random sources under
// several vertex counts and handshake pressures, and checks every result
// beat against a behavioural predictor kept in step with accepted beats.
// ----------------------------------------------------------------------------
module testbench;
  import bfsp_pkg::*;

  localparam int  CYCLE_LIMIT  = 12_000_000;
  localparam int  RANDOM_ITEMS = 460;
  localparam int  SETTLE       = 32;

  localparam longint SUM_MAX = 64'sd140737488355327;
  localparam longint SUM_MIN = -64'sd140737488355328;

  // Command code with no meaning to the block; it must be ignored.
  localparam logic [1:0] FUNC_IDLE = 2'd3;

  typedef struct {
    logic [1:0]                 func;
    logic [VIDX_W-1:0]          from_v;
    logic [VIDX_W-1:0]          to_v;
    logic signed [WEIGHT_W-1:0] weight;
  } command_t;

  typedef struct {
    logic [VIDX_W-1:0]        vertex;
    logic signed [DIST_W-1:0] dval;
    logic                     reach;
    logic [1:0]               status;
    logic                     last;
  } path_result_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  bfsp_in_if  in_ch ();
  bfsp_out_if out_ch ();

  bellman_ford_shortest_paths u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  command_t     pending_cmds[$];
  path_result_t expected_paths[$];
  command_t     cmd_on_bus;

  int send_idle_pct;
  int recv_stall_pct;
  int error_count;
  int results_checked;
  int runs_accepted;
  int neg_cycles_seen;
  int cycle_count;

  // Shadow copy of the block's edge table and distance vectors.
  logic [VIDX_W-1:0]          sh_tail[MAX_EDGES];
  logic [VIDX_W-1:0]          sh_head[MAX_EDGES];
  logic signed [WEIGHT_W-1:0] sh_weight[MAX_EDGES];
  int                         sh_edges;
  int                         sh_vcount;
  longint                     cur_dist[MAX_VERTICES];
  bit                         cur_reach[MAX_VERTICES];
  longint                     nxt_dist[MAX_VERTICES];
  bit                         nxt_reach[MAX_VERTICES];

  // Clock.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // One Jacobi min-plus round from the current vector into the next one.
  function automatic bit relax_round(int n);
    bit     changed;
    longint c;
    changed = 1'b0;
    for (int v = 0; v < n; v++) begin
      nxt_dist[v]  = cur_dist[v];
      nxt_reach[v] = cur_reach[v];
    end
    for (int e = 0; e < sh_edges; e++) begin
      if (sh_tail[e] < n && sh_head[e] < n && cur_reach[sh_tail[e]]) begin
        c = cur_dist[sh_tail[e]] + longint'(sh_weight[e]);
        if (c > SUM_MAX) c = SUM_MAX;
        if (c < SUM_MIN) c = SUM_MIN;
        if (!nxt_reach[sh_head[e]] || c < nxt_dist[sh_head[e]]) begin
          nxt_dist[sh_head[e]]  = c;
          nxt_reach[sh_head[e]] = 1'b1;
        end
      end
    end
    for (int v = 0; v < n; v++)
      if (nxt_reach[v] != cur_reach[v] || (nxt_reach[v] && nxt_dist[v] != cur_dist[v]))
        changed = 1'b1;
    return changed;
  endfunction

  function automatic void expect_status(logic [1:0] st);
    path_result_t r;
    r.vertex = '0;
    r.dval   = '0;
    r.reach  = 1'b0;
    r.status = st;
    r.last   = 1'b1;
    expected_paths.push_back(r);
  endfunction

  // Works out the result beats that one accepted command beat causes.
  function automatic void predict_paths(command_t cmd);
    int           n;
    int           rounds;
    bit           settled;
    path_result_t r;
    case (cmd.func)
      FUNC_LOAD: begin
        if (sh_edges >= MAX_EDGES) begin
          expect_status(ST_FULL);
        end else begin
          sh_tail[sh_edges]   = cmd.from_v;
          sh_head[sh_edges]   = cmd.to_v;
          sh_weight[sh_edges] = cmd.weight;
          sh_edges++;
          expect_status(ST_OK);
        end
      end
      FUNC_CLEAR: begin
        sh_edges = 0;
        expect_status(ST_OK);
      end
      FUNC_RUN: begin
        runs_accepted++;
        n = (sh_vcount == 0) ? 1 : (sh_vcount > MAX_VERTICES) ? MAX_VERTICES : sh_vcount;
        if (cmd.from_v >= n) begin
          expect_status(ST_BAD_SRC);
        end else begin
          for (int v = 0; v < n; v++) begin
            cur_dist[v]  = 0;
            cur_reach[v] = 1'b0;
          end
          cur_reach[cmd.from_v] = 1'b1;
          rounds  = 0;
          settled = 1'b0;
          while (!settled && rounds + 1 < n) begin
            if (relax_round(n)) begin
              cur_dist  = nxt_dist;
              cur_reach = nxt_reach;
            end else begin
              settled = 1'b1;
            end
            rounds++;
          end
          if (!settled && relax_round(n)) begin
            expect_status(ST_NEG_CYC);
          end else begin
            for (int v = 0; v < n; v++) begin
              r.vertex = v[VIDX_W-1:0];
              r.dval   = cur_reach[v] ? cur_dist[v][DIST_W-1:0] : DIST_MAX;
              r.reach  = cur_reach[v];
              r.status = ST_OK;
              r.last   = (v + 1 == n);
              expected_paths.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Command driver: presents queued beats, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict_paths(cmd_on_bus);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_on_bus         = pending_cmds.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.func        <= cmd_on_bus.func;
          in_ch.from_vertex <= cmd_on_bus.from_v;
          in_ch.to_vertex   <= cmd_on_bus.to_v;
          in_ch.edge_weight <= cmd_on_bus.weight;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure and field-by-field comparison.
  always @(posedge clk) begin
    path_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_paths.size() == 0) begin
          $display("%0t: unexpected result beat vertex %0d status %0d", $time,
                   out_ch.vertex_index, out_ch.status);
          error_count++;
        end else begin
          want = expected_paths.pop_front();
          results_checked++;
          if (want.status == ST_NEG_CYC && out_ch.status == ST_NEG_CYC)
            neg_cycles_seen++;
          if (out_ch.vertex_index !== want.vertex || out_ch.distance !== want.dval ||
              out_ch.reachable !== want.reach || out_ch.status !== want.status ||
              out_ch.last !== want.last) begin
            $display("%0t: mismatch expected vtx %0d dist %0d reach %0b st %0d last %0b",
                     $time, want.vertex, want.dval, want.reach, want.status, want.last);
            $display("%0t:          actual   vtx %0d dist %0d reach %0b st %0d last %0b",
                     $time, out_ch.vertex_index, out_ch.distance, out_ch.reachable,
                     out_ch.status, out_ch.last);
            error_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d results outstanding", $time,
               expected_paths.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_cmd(logic [1:0] f, int fv, int tv, logic [31:0] w);
    command_t c;
    c.func   = f;
    c.from_v = fv[VIDX_W-1:0];
    c.to_v   = tv[VIDX_W-1:0];
    c.weight = w;
    pending_cmds.push_back(c);
  endtask

  // Lets every queued beat through and every result out, then settles.
  task automatic drain_block();
    while (pending_cmds.size() != 0 || in_ch.valid || expected_paths.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_vertex_count(int value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sh_vcount = value;
  endtask

  function automatic logic [31:0] random_weight();
    int pick;
    pick = $urandom_range(99);
    if (pick < 12) return $urandom();
    if (pick < 30) return -($urandom_range(8, 1) << 16) - $urandom_range(65535);
    return ($urandom_range(20) << 16) + $urandom_range(65535);
  endfunction

  // Stimulus.
  initial begin
    int n;
    int phase;
    int sent;
    int edges;
    int vcounts[7];
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_LOAD;
    in_ch.from_vertex = '0;
    in_ch.to_vertex   = '0;
    in_ch.edge_weight = '0;
    out_ch.ready      = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    sh_edges          = 0;
    sh_vcount         = 64;
    rst_n             = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme weights, self loop, empty graph, ignored command.
    queue_cmd(FUNC_IDLE, 63, 63, 32'hFFFF_FFFF);
    queue_cmd(FUNC_RUN, 0, 0, 0);
    queue_cmd(FUNC_LOAD, 0, 1, 32'h7FFF_FFFF);
    queue_cmd(FUNC_LOAD, 1, 2, 32'h8000_0000);
    queue_cmd(FUNC_LOAD, 63, 63, 32'h0001_0000);
    queue_cmd(FUNC_LOAD, 2, 63, 32'h0000_8000);
    queue_cmd(FUNC_LOAD, 0, 1, 32'h0002_0000);
    queue_cmd(FUNC_RUN, 0, 0, 0);
    queue_cmd(FUNC_RUN, 63, 0, 0);
    queue_cmd(FUNC_CLEAR, 0, 0, 0);
    queue_cmd(FUNC_RUN, 5, 0, 0);
    drain_block();

    // Directed: small graph with a negative cycle, edges beyond the graph,
    // and a source outside it.
    write_vertex_count(4);
    queue_cmd(FUNC_LOAD, 0, 1, 32'h0003_0000);
    queue_cmd(FUNC_LOAD, 1, 2, 32'hFFFF_0000);
    queue_cmd(FUNC_LOAD, 2, 1, 32'hFFFF_0000);
    queue_cmd(FUNC_LOAD, 10, 3, 32'h0001_0000);
    queue_cmd(FUNC_LOAD, 3, 40, 32'h0001_0000);
    queue_cmd(FUNC_RUN, 0, 0, 0);
    queue_cmd(FUNC_RUN, 3, 0, 0);
    queue_cmd(FUNC_RUN, 4, 0, 0);
    queue_cmd(FUNC_CLEAR, 0, 0, 0);
    drain_block();

    // Directed: fill the edge table, overflow it, then empty it.
    for (int i = 0; i < MAX_EDGES + 2; i++)
      queue_cmd(FUNC_LOAD, $urandom_range(63), $urandom_range(63), $urandom());
    queue_cmd(FUNC_CLEAR, 0, 0, 0);
    drain_block();

    // Random graphs under several vertex counts and handshake pressures.
    vcounts = '{64, 1, 0, 127, 2, 64, 16};
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      if (phase < 7) write_vertex_count(vcounts[phase]);
      else write_vertex_count($urandom_range(10) == 0 ? 64 : $urandom_range(12, 2));
      n = (sh_vcount == 0) ? 1 : (sh_vcount > MAX_VERTICES) ? MAX_VERTICES : sh_vcount;
      queue_cmd(FUNC_CLEAR, 0, 0, 0);
      edges = (n >= 32) ? $urandom_range(24, 4) : $urandom_range(3 * n + 2, 0);
      for (int i = 0; i < edges; i++) begin
        if ($urandom_range(19) == 0)
          queue_cmd(FUNC_LOAD, $urandom_range(63), $urandom_range(63), random_weight());
        else
          queue_cmd(FUNC_LOAD, $urandom_range(n - 1), $urandom_range(n - 1), random_weight());
        if ($urandom_range(24) == 0)
          queue_cmd(FUNC_IDLE, $urandom_range(63), $urandom_range(63), $urandom());
      end
      for (int r = $urandom_range(3, 1); r > 0; r--)
        queue_cmd(FUNC_RUN, ($urandom_range(7) == 0) ? $urandom_range(63)
                                                     : $urandom_range(n - 1), 0, 0);
      sent += pending_cmds.size();
      drain_block();
      phase++;
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    $display("Covered %0d runs (%0d ending in a negative cycle) and %0d checked results,",
             runs_accepted, neg_cycles_seen, results_checked);
    $display("including a full edge table and vertex counts from 0 to 127.");
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
